>>> hw/rtl/sqg_pkg.sv
// ----------------------------------------------------------------------------
// sqg_pkg
// Shared types, codes and fixed-point helpers for the two-qubit gate block.
// ----------------------------------------------------------------------------
package sqg_pkg;

  // fixed field widths
  localparam int AMP_W     = 16;
  localparam int IN_IDX_W  = 5;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;

  // product and rounding widths
  localparam int PROD_W = 2 * AMP_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  typedef logic signed [AMP_W-1:0] amp_t;

  // sqrt(3)/2 rounded to nearest in Q1.15, kept as a positive signed value
  localparam logic signed [AMP_W:0] PHASE_RE = 17'sd28378;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } sqg_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUBIT_COUNT   = 2'd0,
    REG_TARGET_QUBIT  = 2'd1,
    REG_CONTROL_QUBIT = 2'd2,
    REG_MULTIPLY_SIDE = 2'd3
  } sqg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_FIN  = 2'd2
  } sqg_state_t;

  // what the gate does to the addressed element
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_SWAP  = 2'd1,
    KIND_PHASE = 2'd2
  } sqg_kind_t;

  typedef struct packed {
    logic                command;
    logic [IN_IDX_W-1:0] row_index;
    logic [IN_IDX_W-1:0] col_index;
    amp_t                write_real;
    amp_t                write_imag;
  } sqg_in_t;

  typedef struct packed {
    amp_t read_real;
    amp_t read_imag;
    logic error_flag;
  } sqg_out_t;

  // saturate a wide signed value to one amplitude
  function automatic amp_t sat_amp(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'($signed({1'b0, {(AMP_W-1){1'b1}}}));
    lo = -hi - SUM_W'(1);
    if (v > hi) return {1'b0, {(AMP_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(AMP_W-1){1'b0}}};
    return v[AMP_W-1:0];
  endfunction

  // negate with saturation: most negative maps to most positive
  function automatic amp_t neg_sat(input amp_t v);
    if (v == {1'b1, {(AMP_W-1){1'b0}}}) return {1'b0, {(AMP_W-1){1'b1}}};
    return -v;
  endfunction

endpackage

>>> hw/rtl/sqg_ram.sv
// ----------------------------------------------------------------------------
// sqg_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sqg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/two_qubit_sycamore_gate_apply.sv
// ----------------------------------------------------------------------------
// two_qubit_sycamore_gate_apply
// Stores a 2^n by 2^n complex Q1.15 matrix and returns elements of the
// matrix with the fixed two-qubit phase/swap gate applied on row or column.
// ----------------------------------------------------------------------------
// Each request is handled in turn. A write is done in ST_IDLE and gives no
// result unless its indices are out of range. A read passes from acceptance
// to the result register through ST_IDLE, which issues the amplitude memory
// read, ST_READ, which captures the data and forms the two constant products,
// and ST_FIN, which rounds, saturates and loads the result. A request that
// fails its checks goes from ST_IDLE straight to ST_FIN. ST_FIN waits while
// an earlier result still waits on out_ready; the result register lets a new
// request enter while that earlier result waits. Memory contents are undefined
// after reset; reading an element never written returns an arbitrary value.
module two_qubit_sycamore_gate_apply
  import sqg_pkg::*;
#(
  parameter int MAX_QUBITS = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sqg_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sqg_out_t             out_data
);

  localparam int IDX_W  = MAX_QUBITS;
  localparam int ADDR_W = 2 * MAX_QUBITS;
  localparam int DEPTH  = 1 << ADDR_W;

  // configuration registers
  logic [CFG_W-1:0] qubit_count_r;
  logic [CFG_W-1:0] target_r;
  logic [CFG_W-1:0] control_r;
  logic             side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubit_count_r <= CFG_W'(2);
      target_r      <= CFG_W'(0);
      control_r     <= CFG_W'(1);
      side_r        <= 1'b0;
    end else if (cfg_we) begin
      case (sqg_reg_t'(cfg_index))
        REG_QUBIT_COUNT:   qubit_count_r <= cfg_wdata;
        REG_TARGET_QUBIT:  target_r      <= cfg_wdata;
        REG_CONTROL_QUBIT: control_r     <= cfg_wdata;
        REG_MULTIPLY_SIDE: side_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control and payload registers
  sqg_state_t state_r, state_nxt;
  sqg_kind_t  kind_r, kind_nxt;
  logic       err_r, err_nxt;
  logic       out_valid_r, out_valid_nxt;
  sqg_out_t   out_data_r, out_data_nxt;
  amp_t       a_r, a_nxt;
  amp_t       b_r, b_nxt;
  logic signed [PROD_W-1:0] pa_r, pa_nxt;
  logic signed [PROD_W-1:0] pb_r, pb_nxt;

  // memory interface
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [2*AMP_W-1:0]   ram_rdata;

  // request decode and checks
  logic             size_bad;
  logic             gate_bad;
  logic [IDX_W-1:0] row_i, col_i, gate_i, gate_sh, flip;
  logic             tb, cb;

  always_comb begin
    size_bad = (qubit_count_r < CFG_W'(2)) ||
               ({1'b0, qubit_count_r} > 4'(MAX_QUBITS)) ||
               ((in_data.row_index >> qubit_count_r) != '0) ||
               ((in_data.col_index >> qubit_count_r) != '0);
    gate_bad = (target_r == control_r) || (target_r >= qubit_count_r) ||
               (control_r >= qubit_count_r);
    row_i   = IDX_W'(in_data.row_index);
    col_i   = IDX_W'(in_data.col_index);
    gate_i  = side_r ? col_i : row_i;
    gate_sh = gate_i >> target_r;
    tb      = gate_sh[0];
    gate_sh = gate_i >> control_r;
    cb      = gate_sh[0];
    flip    = (IDX_W'(1) << target_r) | (IDX_W'(1) << control_r);
    // partner element for the swap case, reads only
    if (in_data.command == CMD_READ && tb != cb) begin
      if (side_r) col_i = col_i ^ flip;
      else        row_i = row_i ^ flip;
    end
    ram_addr = {row_i, col_i};
  end

  // rounding sums for the phase product
  logic signed [SUM_W-1:0] half;
  logic signed [SUM_W-1:0] re_sum, im_sum;
  logic signed [SUM_W-1:0] re_shift, im_shift;

  always_comb begin
    half     = SUM_W'(1) <<< (AMP_W - 2);
    re_sum   = SUM_W'(pa_r) + (SUM_W'(b_r) <<< (AMP_W - 2)) + half;
    im_sum   = SUM_W'(pb_r) - (SUM_W'(a_r) <<< (AMP_W - 2)) + half;
    re_shift = re_sum >>> (AMP_W - 1);
    im_shift = im_sum >>> (AMP_W - 1);
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    in_ready      = (state_r == ST_IDLE);
    ram_we        = 1'b0;

    // result taken downstream
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (size_bad) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (in_data.command == CMD_WRITE) begin
            ram_we = 1'b1;
          end else if (gate_bad) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            err_nxt   = 1'b0;
            if (tb != cb)  kind_nxt = KIND_SWAP;
            else if (tb)   kind_nxt = KIND_PHASE;
            else           kind_nxt = KIND_PASS;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        a_nxt     = ram_rdata[2*AMP_W-1:AMP_W];
        b_nxt     = ram_rdata[AMP_W-1:0];
        pa_nxt    = PROD_W'($signed(ram_rdata[2*AMP_W-1:AMP_W])) * PROD_W'(PHASE_RE);
        pb_nxt    = PROD_W'($signed(ram_rdata[AMP_W-1:0])) * PROD_W'(PHASE_RE);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_data_nxt = '{read_real: '0, read_imag: '0, error_flag: 1'b1};
          end else begin
            case (kind_r)
              KIND_SWAP:  out_data_nxt = '{read_real: b_r, read_imag: neg_sat(a_r),
                                           error_flag: 1'b0};
              KIND_PHASE: out_data_nxt = '{read_real: sat_amp(re_shift),
                                           read_imag: sat_amp(im_shift),
                                           error_flag: 1'b0};
              default:    out_data_nxt = '{read_real: a_r, read_imag: b_r,
                                           error_flag: 1'b0};
            endcase
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
  end

  // amplitude store, real part in the upper half
  sqg_ram #(
    .WIDTH (2 * AMP_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata ({in_data.write_real, in_data.write_imag}),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/sv/sqg_gate_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// sqg_gate_scoreboard_pkg
// Predicts the gate-applied matrix element for each accepted request and
// compares the block's results against those predictions in order.
// ----------------------------------------------------------------------------
package sqg_gate_scoreboard_pkg;
  import sqg_pkg::*;

  localparam int     GATE_QUBITS_MAX = 5;
  localparam int     STORE_ENTRIES   = 1 << (2 * GATE_QUBITS_MAX);
  localparam amp_t   AMP_TOP         = 16'sh7FFF;
  localparam amp_t   AMP_BOTTOM      = 16'sh8000;
  // sqrt(3)/2 and -0.5 in Q1.15
  localparam longint PHASE_COS       = 28378;
  localparam longint PHASE_SIN       = -16384;
  localparam longint ROUND_HALF      = 16384;

  class gate_scoreboard;
    amp_t             stored_real [STORE_ENTRIES];
    amp_t             stored_imag [STORE_ENTRIES];
    bit               stored_flag [STORE_ENTRIES];
    logic [CFG_W-1:0] qubit_count;
    logic [CFG_W-1:0] target_qubit;
    logic [CFG_W-1:0] control_qubit;
    logic             multiply_side;
    sqg_out_t         gated_results[$];
    int               errors;

    function new();
      foreach (stored_flag[i]) stored_flag[i] = 1'b0;
      qubit_count   = 3'd2;
      target_qubit  = 3'd0;
      control_qubit = 3'd1;
      multiply_side = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(sqg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_QUBIT_COUNT:   qubit_count   = value;
        REG_TARGET_QUBIT:  target_qubit  = value;
        REG_CONTROL_QUBIT: control_qubit = value;
        REG_MULTIPLY_SIDE: multiply_side = value[0];
        default: ;
      endcase
    endfunction

    // matrix side, zero when the qubit count is unusable
    function int side();
      if (qubit_count < 2 || qubit_count > GATE_QUBITS_MAX) return 0;
      return 1 << qubit_count;
    endfunction

    function bit in_range(logic [IN_IDX_W-1:0] row, logic [IN_IDX_W-1:0] col);
      return side() != 0 && row < side() && col < side();
    endfunction

    function bit gate_ok();
      return target_qubit != control_qubit && target_qubit < qubit_count &&
             control_qubit < qubit_count;
    endfunction

    function bit fetches_memory(sqg_in_t req);
      return req.command == CMD_READ && in_range(req.row_index, req.col_index) && gate_ok();
    endfunction

    // address of the element a good read actually fetches (partner on swap)
    function logic [9:0] source_addr(sqg_in_t req);
      logic [IN_IDX_W-1:0] row;
      logic [IN_IDX_W-1:0] col;
      logic [IN_IDX_W-1:0] idx;
      logic [IN_IDX_W-1:0] flip;
      row  = req.row_index;
      col  = req.col_index;
      idx  = multiply_side ? col : row;
      flip = (5'd1 << target_qubit) | (5'd1 << control_qubit);
      if (idx[target_qubit] != idx[control_qubit]) begin
        if (multiply_side) col = col ^ flip;
        else row = row ^ flip;
      end
      return {row, col};
    endfunction

    function amp_t clamp_amp(longint v);
      if (v > longint'(AMP_TOP)) return AMP_TOP;
      if (v < longint'(AMP_BOTTOM)) return AMP_BOTTOM;
      return amp_t'(v);
    endfunction

    // element of G*M or M*G for a read that passed its checks
    function sqg_out_t gated_element(sqg_in_t req);
      sqg_out_t            res;
      sqg_kind_t           kind;
      logic [IN_IDX_W-1:0] idx;
      logic [9:0]          addr;
      longint              a;
      longint              b;
      longint              re;
      longint              im;
      idx  = multiply_side ? req.col_index : req.row_index;
      if (idx[target_qubit] != idx[control_qubit]) kind = KIND_SWAP;
      else if (idx[target_qubit]) kind = KIND_PHASE;
      else kind = KIND_PASS;
      addr = source_addr(req);
      a    = longint'(stored_real[addr]);
      b    = longint'(stored_imag[addr]);
      res  = '0;
      case (kind)
        KIND_SWAP: begin
          // times -i: (a + bi) becomes b - ai
          res.read_real = clamp_amp(b);
          res.read_imag = clamp_amp(-a);
        end
        KIND_PHASE: begin
          re = a * PHASE_COS - b * PHASE_SIN;
          im = a * PHASE_SIN + b * PHASE_COS;
          res.read_real = clamp_amp((re + ROUND_HALF) >>> 15);
          res.read_imag = clamp_amp((im + ROUND_HALF) >>> 15);
        end
        default: begin
          res.read_real = amp_t'(a);
          res.read_imag = amp_t'(b);
        end
      endcase
      return res;
    endfunction

    function void note_request(sqg_in_t req);
      sqg_out_t   res;
      logic [9:0] addr;
      res = '0;
      res.error_flag = 1'b1;
      if (!in_range(req.row_index, req.col_index)) begin
        gated_results.push_back(res);
        return;
      end
      if (req.command == CMD_WRITE) begin
        addr = {req.row_index, req.col_index};
        stored_real[addr] = req.write_real;
        stored_imag[addr] = req.write_imag;
        stored_flag[addr] = 1'b1;
        return;
      end
      if (!gate_ok()) begin
        gated_results.push_back(res);
        return;
      end
      gated_results.push_back(gated_element(req));
    endfunction

    function void check_result(sqg_out_t got);
      sqg_out_t want;
      if (gated_results.size() == 0) begin
        $error("result with no request waiting: real %0d imag %0d error_flag %0b",
               $signed(got.read_real), $signed(got.read_imag), got.error_flag);
        errors++;
        return;
      end
      want = gated_results.pop_front();
      if (got.read_real !== want.read_real) begin
        $error("read_real mismatch: expected %0d, got %0d",
               $signed(want.read_real), $signed(got.read_real));
        errors++;
      end
      if (got.read_imag !== want.read_imag) begin
        $error("read_imag mismatch: expected %0d, got %0d",
               $signed(want.read_imag), $signed(got.read_imag));
        errors++;
      end
      if (got.error_flag !== want.error_flag) begin
        $error("error_flag mismatch: expected %0b, got %0b", want.error_flag, got.error_flag);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/two_qubit_sycamore_gate_apply_test.sv
// ----------------------------------------------------------------------------
// two_qubit_sycamore_gate_apply_test
// Drives element writes and gate-applied reads through the request and result
// handshakes under several register settings, with random stalls on both
// sides, and checks every result against an in-order prediction.
// ----------------------------------------------------------------------------
module two_qubit_sycamore_gate_apply_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sqg_pkg::*;
  import sqg_gate_scoreboard_pkg::*;

  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_REQUESTS  = 92;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_AT_REQUEST = 500;
  localparam int HOLD_CYCLES     = 300;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  sqg_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sqg_out_t             out_data;

  gate_scoreboard sb = new();
  logic [9:0]     stored_addrs[$];
  int             accepted_count = 0;
  bit             idle_on = 1'b1;

  two_qubit_sycamore_gate_apply uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin : receiver
    int burst;
    int hold;
    bit held;
    burst = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && accepted_count >= HOLD_AT_REQUEST) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic pause(input int cycles);
    @(negedge clk) in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // present one request and hold it until accepted
  task automatic offer(input sqg_in_t req);
    if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 5));
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    accepted_count++;
  endtask

  // drop the request line, wait for every result and let writes finish
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.gated_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] tgt,
                           input logic [CFG_W-1:0] ctl, input logic mside);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_QUBIT_COUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_index <= REG_TARGET_QUBIT;
    cfg_wdata <= tgt;
    @(negedge clk);
    cfg_index <= REG_CONTROL_QUBIT;
    cfg_wdata <= ctl;
    @(negedge clk);
    cfg_index <= REG_MULTIPLY_SIDE;
    cfg_wdata <= {2'b00, mside};
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_reg(REG_QUBIT_COUNT, count);
    sb.set_reg(REG_TARGET_QUBIT, tgt);
    sb.set_reg(REG_CONTROL_QUBIT, ctl);
    sb.set_reg(REG_MULTIPLY_SIDE, {2'b00, mside});
  endtask

  function automatic sqg_in_t element_request(input logic cmd, input int row, input int col,
                                              input amp_t re, input amp_t im);
    sqg_in_t req;
    req.command    = cmd;
    req.row_index  = IN_IDX_W'(row);
    req.col_index  = IN_IDX_W'(col);
    req.write_real = re;
    req.write_imag = im;
    return req;
  endfunction

  // mostly in-range writes and reads of stored elements, some noise
  function automatic sqg_in_t make_request();
    sqg_in_t    req;
    int         span;
    int         roll;
    logic [9:0] addr;
    span = sb.side();
    roll = $urandom_range(0, 99);
    req.write_real = amp_t'($urandom);
    req.write_imag = amp_t'($urandom);
    if (roll % 9 == 0) req.write_real = $urandom_range(0, 1) ? AMP_TOP : AMP_BOTTOM;
    if (roll % 7 == 0) req.write_imag = $urandom_range(0, 1) ? AMP_TOP : AMP_BOTTOM;
    if (span == 0 || roll < 10) begin
      req.command   = 1'($urandom_range(0, 1));
      req.row_index = IN_IDX_W'($urandom_range(0, 31));
      req.col_index = IN_IDX_W'($urandom_range(0, 31));
    end else if (roll < 50) begin
      req.command   = CMD_WRITE;
      req.row_index = IN_IDX_W'($urandom_range(0, span - 1));
      req.col_index = IN_IDX_W'($urandom_range(0, span - 1));
    end else begin
      req.command   = CMD_READ;
      req.row_index = IN_IDX_W'($urandom_range(0, span - 1));
      req.col_index = IN_IDX_W'($urandom_range(0, span - 1));
      for (int k = 0; k < 4 && stored_addrs.size() != 0; k++) begin
        addr = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
        if (sb.in_range(addr[9:5], addr[4:0])) begin
          req.row_index = addr[9:5];
          req.col_index = addr[4:0];
          break;
        end
      end
    end
    // never fetch an element that was not stored: store it instead
    if (sb.fetches_memory(req)) begin
      addr = sb.source_addr(req);
      if (!sb.stored_flag[addr]) begin
        req.command   = CMD_WRITE;
        req.row_index = addr[9:5];
        req.col_index = addr[4:0];
      end
    end
    if (req.command == CMD_WRITE && sb.in_range(req.row_index, req.col_index) &&
        !sb.stored_flag[{req.row_index, req.col_index}])
      stored_addrs.push_back({req.row_index, req.col_index});
    return req;
  endfunction

  initial begin : main
    logic [CFG_W-1:0] count;
    logic [CFG_W-1:0] tgt;
    logic [CFG_W-1:0] ctl;
    int               usable;
    int               pick;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 4x4, gate on rows, target bit 0, control bit 1
    offer(element_request(CMD_WRITE, 0, 0, AMP_TOP, AMP_BOTTOM));
    offer(element_request(CMD_WRITE, 1, 3, AMP_BOTTOM, AMP_TOP));
    offer(element_request(CMD_WRITE, 2, 3, AMP_BOTTOM, AMP_BOTTOM));
    offer(element_request(CMD_WRITE, 3, 0, AMP_BOTTOM, AMP_BOTTOM));
    offer(element_request(CMD_WRITE, 3, 3, AMP_TOP, AMP_TOP));
    // untouched element
    offer(element_request(CMD_READ, 0, 0, '0, '0));
    // swap with saturating negation, both partner directions
    offer(element_request(CMD_READ, 2, 3, '0, '0));
    offer(element_request(CMD_READ, 1, 3, '0, '0));
    // phase rotation saturating at both ends
    offer(element_request(CMD_READ, 3, 3, '0, '0));
    offer(element_request(CMD_READ, 3, 0, '0, '0));
    // out-of-range indices on write and read
    offer(element_request(CMD_WRITE, 4, 0, 16'sd1, 16'sd1));
    offer(element_request(CMD_WRITE, 0, 31, 16'sd1, 16'sd1));
    offer(element_request(CMD_READ, 31, 31, '0, '0));
    settle();

    // largest matrix, gate on columns, qubits at the extremes
    configure(3'd5, 3'd4, 3'd0, 1'b1);
    offer(element_request(CMD_WRITE, 31, 1, 16'sh1234, -16'sd1));
    offer(element_request(CMD_WRITE, 31, 31, 16'sd1, -16'sd1));
    offer(element_request(CMD_READ, 31, 16, '0, '0));
    offer(element_request(CMD_READ, 31, 31, '0, '0));
    offer(element_request(CMD_READ, 0, 0, '0, '0));
    settle();

    // equal qubits: writes still land, reads fail
    configure(3'd3, 3'd2, 3'd2, 1'b0);
    offer(element_request(CMD_WRITE, 7, 7, 16'sd0, 16'sd0));
    offer(element_request(CMD_READ, 0, 0, '0, '0));
    settle();

    // qubit count beyond the limit
    configure(3'd7, 3'd0, 3'd1, 1'b0);
    offer(element_request(CMD_WRITE, 0, 0, 16'sd5, 16'sd5));
    offer(element_request(CMD_READ, 0, 0, '0, '0));
    settle();

    // target qubit above the count
    configure(3'd2, 3'd3, 3'd0, 1'b0);
    offer(element_request(CMD_READ, 0, 0, '0, '0));
    settle();

    // random phases, each under its own settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        count = 3'd5; tgt = 3'd0; ctl = 3'd4;
      end else if (phase == 1) begin
        count = 3'd2; tgt = 3'd1; ctl = 3'd0;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          pick  = $urandom_range(0, 3);
          count = (pick < 2) ? CFG_W'(pick) : CFG_W'(pick + 4);
        end else begin
          count = CFG_W'($urandom_range(2, 5));
        end
        usable = (count >= 2 && count <= 5) ? int'(count) : 5;
        if ($urandom_range(0, 4) == 0) begin
          tgt = CFG_W'($urandom_range(0, 7));
          ctl = CFG_W'($urandom_range(0, 7));
        end else begin
          tgt = CFG_W'($urandom_range(0, usable - 1));
          ctl = CFG_W'((int'(tgt) + $urandom_range(1, usable - 1)) % usable);
        end
      end
      configure(count, tgt, ctl,
                phase == 1 ? 1'b0 : (phase == 0 ? 1'b1 : 1'($urandom_range(0, 1))));
      idle_on = (phase == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_REQUESTS; n++) offer(make_request());
      settle();
    end

    if (sb.errors == 0 && sb.gated_results.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
